[rtl/icsr_pkg.sv]
// ----------------------------------------------------------------------------
// icsr_pkg
// Types and constants shared by the chunk stream to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package icsr_pkg;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_TAG1,
    PH_TAG2,
    PH_LEN,
    PH_DATA,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_AT,
    TAG_CM,
    TAG_PD
  } tag_t;

  typedef enum logic [1:0] {
    ST_PIXEL,
    ST_CM_EARLY,
    ST_TRUNCATED,
    ST_NO_PIXELS
  } status_t;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_PIXEL_MAPPED,
    OP_REPORT
  } op_t;

  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_C     = 8'h43;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam int unsigned SIG_BYTES = 8;

  typedef struct packed {
    op_t         op;
    logic [7:0]  index;
    logic        in_range;
    logic [13:0] column;
    logic [13:0] pixel_row;
    logic        row_end;
    logic        image_end;
    status_t     status;
  } cmd_t;

  typedef struct packed {
    logic        write;
    logic [7:0]  addr;
    logic [23:0] data;
  } pal_wr_t;

endpackage

`default_nettype wire

[rtl/icsr_front.sv]
// ----------------------------------------------------------------------------
// icsr_front
// Parses the byte stream, keeps the header state and writes the palette,
// and issues one command per pixel or error report.
// ----------------------------------------------------------------------------
`default_nettype none

module icsr_front
  import icsr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int LENGTH_DIGITS   = 8,
  parameter int HEADER_DIGITS   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       stream_end,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  wire logic       cmd_ready,
  output pal_wr_t         pal_wr
);

  localparam int HDR_BYTES = 3 * HEADER_DIGITS;

  phase_t      phase, phase_next;
  tag_t        current_tag, current_tag_next;
  logic [3:0]  field_counter, field_counter_next;
  logic [26:0] length_accum, length_accum_next;
  logic [26:0] bytes_left, bytes_left_next;
  logic [7:0]  tag_first_byte, tag_first_byte_next;
  logic [13:0] image_width, image_width_next;
  logic [13:0] image_height, image_height_next;
  logic [13:0] header_color_count, header_color_count_next;
  logic [8:0]  loaded_colors, loaded_colors_next;
  logic [15:0] triplet_bytes, triplet_bytes_next;
  logic [1:0]  triplet_position, triplet_position_next;
  logic [13:0] column_count, column_count_next;
  logic [13:0] row_count, row_count_next;
  logic        seen_attributes, seen_attributes_next;
  logic        seen_colormap, seen_colormap_next;
  logic        seen_pixels, seen_pixels_next;
  logic        len_digit_seen, len_digit_seen_next;
  logic        len_ended, len_ended_next;
  logic [26:0] pixel_total;
  logic        cmd_valid_next;
  cmd_t        cmd_next;
  pal_wr_t     pal_wr_next;

  logic        fire;
  logic        is_digit;
  logic [3:0]  digit;
  logic [8:0]  color_limit;

  assign in_ready = (phase != PH_HALT) && (!cmd_valid || cmd_ready);
  assign fire     = in_valid && in_ready;
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign digit    = is_digit ? 4'(data_byte - CHAR_ZERO) : 4'd0;

  always_ff @(posedge clk) begin
    pixel_total <= 27'(image_width * image_height);
  end

  always_comb begin
    if (header_color_count < 14'(PALETTE_ENTRIES)) begin
      color_limit = 9'(header_color_count);
    end else begin
      color_limit = 9'(PALETTE_ENTRIES);
    end
  end

  function automatic logic [13:0] hdr_next(input logic [13:0] v, input logic [3:0] d);
    hdr_next = 14'(v * 14'd10 + 14'(d));
  endfunction

  always_comb begin
    phase_next              = phase;
    current_tag_next        = current_tag;
    field_counter_next      = field_counter;
    length_accum_next       = length_accum;
    bytes_left_next         = bytes_left;
    tag_first_byte_next     = tag_first_byte;
    image_width_next        = image_width;
    image_height_next       = image_height;
    header_color_count_next = header_color_count;
    loaded_colors_next      = loaded_colors;
    triplet_bytes_next      = triplet_bytes;
    triplet_position_next   = triplet_position;
    column_count_next       = column_count;
    row_count_next          = row_count;
    seen_attributes_next    = seen_attributes;
    seen_colormap_next      = seen_colormap;
    seen_pixels_next        = seen_pixels;
    len_digit_seen_next     = len_digit_seen;
    len_ended_next          = len_ended;
    cmd_valid_next          = cmd_valid && !cmd_ready;
    cmd_next                = cmd;
    pal_wr_next             = '{write: 1'b0, addr: 8'd0, data: 24'd0};

    if (fire) begin
      unique case (phase)
        PH_SIG: begin
          if (32'(field_counter) + 1 >= SIG_BYTES) begin
            field_counter_next = 4'd0;
            phase_next         = PH_TAG1;
          end else begin
            field_counter_next = field_counter + 4'd1;
          end
        end
        PH_TAG1: begin
          tag_first_byte_next = data_byte;
          phase_next          = PH_TAG2;
        end
        PH_TAG2: begin
          phase_next          = PH_LEN;
          field_counter_next  = 4'd0;
          length_accum_next   = 27'd0;
          len_digit_seen_next = 1'b0;
          len_ended_next      = 1'b0;
          priority if (tag_first_byte == CHAR_A && data_byte == CHAR_T) begin
            current_tag_next = TAG_AT;
          end else if (tag_first_byte == CHAR_C && data_byte == CHAR_M) begin
            current_tag_next = TAG_CM;
            if (!seen_attributes) begin
              phase_next     = PH_HALT;
              cmd_valid_next = 1'b1;
              cmd_next       = '0;
              cmd_next.op    = OP_REPORT;
              cmd_next.status = ST_CM_EARLY;
            end
          end else if (tag_first_byte == CHAR_P && data_byte == CHAR_D) begin
            current_tag_next = TAG_PD;
          end else begin
            phase_next = PH_TAG1;
          end
        end
        PH_LEN: begin
          if (!len_ended) begin
            if (is_digit) begin
              length_accum_next   = 27'(length_accum * 27'd10 + 27'(digit));
              len_digit_seen_next = 1'b1;
            end else if (len_digit_seen || data_byte != CHAR_SPACE) begin
              len_ended_next = 1'b1;
            end
          end
          if (32'(field_counter) + 1 < LENGTH_DIGITS) begin
            field_counter_next = field_counter + 4'd1;
          end else begin
            field_counter_next = 4'd0;
            unique case (current_tag)
              TAG_AT: begin
                bytes_left_next         = length_accum_next;
                image_width_next        = 14'd0;
                image_height_next       = 14'd0;
                header_color_count_next = 14'd0;
              end
              TAG_CM: begin
                bytes_left_next       = length_accum_next;
                loaded_colors_next    = 9'd0;
                triplet_position_next = 2'd0;
                triplet_bytes_next    = 16'd0;
              end
              default: begin
                bytes_left_next   = pixel_total;
                column_count_next = 14'd0;
                row_count_next    = 14'd0;
              end
            endcase
            if (bytes_left_next == 27'd0) begin
              phase_next = PH_TAG1;
              unique case (current_tag)
                TAG_AT:  seen_attributes_next = 1'b1;
                TAG_CM:  seen_colormap_next   = 1'b1;
                TAG_PD:  seen_pixels_next     = 1'b1;
                default: ;
              endcase
              current_tag_next = TAG_NONE;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          unique case (current_tag)
            TAG_AT: begin
              if (32'(field_counter) < HDR_BYTES) begin
                if (32'(field_counter) < HEADER_DIGITS) begin
                  image_width_next = hdr_next(image_width, digit);
                end else if (32'(field_counter) < 2 * HEADER_DIGITS) begin
                  image_height_next = hdr_next(image_height, digit);
                end else begin
                  header_color_count_next = hdr_next(header_color_count, digit);
                end
                field_counter_next = field_counter + 4'd1;
              end
            end
            TAG_CM: begin
              if (triplet_position < 2'd2) begin
                triplet_bytes_next    = {triplet_bytes[7:0], data_byte};
                triplet_position_next = triplet_position + 2'd1;
              end else begin
                if (loaded_colors < color_limit) begin
                  pal_wr_next.write  = 1'b1;
                  pal_wr_next.addr   = loaded_colors[7:0];
                  pal_wr_next.data   = {triplet_bytes, data_byte};
                  loaded_colors_next = loaded_colors + 9'd1;
                end
                triplet_position_next = 2'd0;
                triplet_bytes_next    = 16'd0;
              end
            end
            default: begin
              cmd_valid_next     = 1'b1;
              cmd_next.op        = seen_colormap ? OP_PIXEL_MAPPED : OP_PIXEL;
              cmd_next.index     = data_byte;
              cmd_next.in_range  = (9'(data_byte) < loaded_colors);
              cmd_next.column    = column_count;
              cmd_next.pixel_row = row_count;
              cmd_next.row_end   = (15'(column_count) + 15'd1 >= 15'(image_width));
              cmd_next.image_end = (bytes_left == 27'd1);
              cmd_next.status    = ST_PIXEL;
              if (cmd_next.row_end) begin
                column_count_next = 14'd0;
                row_count_next    = row_count + 14'd1;
              end else begin
                column_count_next = column_count + 14'd1;
              end
            end
          endcase
          bytes_left_next = bytes_left - 27'd1;
          if (bytes_left_next == 27'd0) begin
            phase_next = PH_TAG1;
            unique case (current_tag)
              TAG_AT:  seen_attributes_next = 1'b1;
              TAG_CM:  seen_colormap_next   = 1'b1;
              TAG_PD:  seen_pixels_next     = 1'b1;
              default: ;
            endcase
            current_tag_next = TAG_NONE;
          end
        end
        default: ;
      endcase

      if (stream_end && phase_next != PH_HALT) begin
        if (phase_next == PH_LEN || phase_next == PH_DATA) begin
          phase_next      = PH_HALT;
          cmd_valid_next  = 1'b1;
          cmd_next        = '0;
          cmd_next.op     = OP_REPORT;
          cmd_next.status = ST_TRUNCATED;
        end else if (!seen_pixels_next) begin
          phase_next      = PH_HALT;
          cmd_valid_next  = 1'b1;
          cmd_next        = '0;
          cmd_next.op     = OP_REPORT;
          cmd_next.status = ST_NO_PIXELS;
        end else begin
          phase_next              = PH_SIG;
          current_tag_next        = TAG_NONE;
          field_counter_next      = 4'd0;
          length_accum_next       = 27'd0;
          bytes_left_next         = 27'd0;
          tag_first_byte_next     = 8'd0;
          image_width_next        = 14'd0;
          image_height_next       = 14'd0;
          header_color_count_next = 14'd0;
          loaded_colors_next      = 9'd0;
          triplet_bytes_next      = 16'd0;
          triplet_position_next   = 2'd0;
          column_count_next       = 14'd0;
          row_count_next          = 14'd0;
          seen_attributes_next    = 1'b0;
          seen_colormap_next      = 1'b0;
          seen_pixels_next        = 1'b0;
          len_digit_seen_next     = 1'b0;
          len_ended_next          = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
    if (rst) begin
      phase              <= PH_SIG;
      current_tag        <= TAG_NONE;
      field_counter      <= 4'd0;
      length_accum       <= 27'd0;
      bytes_left         <= 27'd0;
      tag_first_byte     <= 8'd0;
      image_width        <= 14'd0;
      image_height       <= 14'd0;
      header_color_count <= 14'd0;
      loaded_colors      <= 9'd0;
      triplet_bytes      <= 16'd0;
      triplet_position   <= 2'd0;
      column_count       <= 14'd0;
      row_count          <= 14'd0;
      seen_attributes    <= 1'b0;
      seen_colormap      <= 1'b0;
      seen_pixels        <= 1'b0;
      len_digit_seen     <= 1'b0;
      len_ended          <= 1'b0;
      cmd_valid          <= 1'b0;
      pal_wr.write       <= 1'b0;
    end else begin
      phase              <= phase_next;
      current_tag        <= current_tag_next;
      field_counter      <= field_counter_next;
      length_accum       <= length_accum_next;
      bytes_left         <= bytes_left_next;
      tag_first_byte     <= tag_first_byte_next;
      image_width        <= image_width_next;
      image_height       <= image_height_next;
      header_color_count <= header_color_count_next;
      loaded_colors      <= loaded_colors_next;
      triplet_bytes      <= triplet_bytes_next;
      triplet_position   <= triplet_position_next;
      column_count       <= column_count_next;
      row_count          <= row_count_next;
      seen_attributes    <= seen_attributes_next;
      seen_colormap      <= seen_colormap_next;
      seen_pixels        <= seen_pixels_next;
      len_digit_seen     <= len_digit_seen_next;
      len_ended          <= len_ended_next;
      cmd_valid          <= cmd_valid_next;
      pal_wr             <= pal_wr_next;
    end
  end

endmodule

`default_nettype wire

[rtl/icsr_back.sv]
// ----------------------------------------------------------------------------
// icsr_back
// Holds the palette memory and turns commands into output pixels through
// a two-stage pipeline: palette read, then output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icsr_back
  import icsr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_ready,
  input  pal_wr_t          pal_wr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [13:0]      column,
  output logic [13:0]      pixel_row,
  output logic             row_end,
  output logic             image_end,
  output logic [1:0]       status
);

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0] palette [PALETTE_ENTRIES];
  logic [23:0] rd_data;
  logic        s1_valid;
  cmd_t        s1_cmd;
  cmd_t        cmd_in;
  logic        s1_ready;
  logic [23:0] rgb;
  logic        idx_ok;

  assign s1_ready  = !out_valid || out_ready;
  assign cmd_ready = !s1_valid || s1_ready;
  assign idx_ok    = 32'(cmd.index) < PALETTE_ENTRIES;

  always_comb begin
    cmd_in          = cmd;
    cmd_in.in_range = cmd.in_range && idx_ok;
  end

  always_ff @(posedge clk) begin
    if (pal_wr.write) begin
      palette[pal_wr.addr[AW-1:0]] <= pal_wr.data;
    end
    if (cmd_valid && cmd_ready) begin
      rd_data <= palette[cmd.index[AW-1:0]];
      s1_cmd  <= cmd_in;
    end
  end

  always_comb begin
    unique case (s1_cmd.op)
      OP_PIXEL:        rgb = {3{s1_cmd.index}};
      OP_PIXEL_MAPPED: rgb = s1_cmd.in_range ? rd_data : 24'd0;
      default:         rgb = 24'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      {red, green, blue} <= rgb;
      column    <= s1_cmd.column;
      pixel_row <= s1_cmd.pixel_row;
      row_end   <= s1_cmd.row_end;
      image_end <= s1_cmd.image_end;
      status    <= s1_cmd.status;
    end
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_ready) begin
        s1_valid <= cmd_valid;
      end
      if (s1_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/img_chunk_stream_to_rgb.sv]
// ----------------------------------------------------------------------------
// img_chunk_stream_to_rgb
// Chunked image byte stream to RGB pixel converter.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock unless out_ready holds it back,
// and gives at most one pixel or error report per byte. The front end parses
// signature, tags, lengths and headers and writes the palette; a command
// register passes each pixel to the back end, which reads the palette and
// registers the result. A pixel passes the command register, the palette
// read register and the output register before it is valid on the outputs.
// After an error report the block takes no more bytes until reset.
`default_nettype none

module img_chunk_stream_to_rgb
  import icsr_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int LENGTH_DIGITS   = 8,
  parameter int HEADER_DIGITS   = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        stream_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       red,
  output logic [7:0]       green,
  output logic [7:0]       blue,
  output logic [13:0]      column,
  output logic [13:0]      pixel_row,
  output logic             row_end,
  output logic             image_end,
  output logic [1:0]       status
);

  logic    cmd_valid;
  logic    cmd_ready;
  cmd_t    cmd;
  pal_wr_t pal_wr;

  icsr_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .LENGTH_DIGITS  (LENGTH_DIGITS),
    .HEADER_DIGITS  (HEADER_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .stream_end(stream_end),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready),
    .pal_wr    (pal_wr)
  );

  icsr_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_ready(cmd_ready),
    .pal_wr   (pal_wr),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .column   (column),
    .pixel_row(pixel_row),
    .row_end  (row_end),
    .image_end(image_end),
    .status   (status)
  );

endmodule

`default_nettype wire
